/* hw/rtl/rop_pkg.sv */
// Reticle overlay package: coordinate and color widths, request/result
// payload structs, rectangle and hit types. No dependencies.
package rop_pkg;

  localparam int COORD_BITS = 12;
  localparam int COLOR_BITS = 32;
  // Bounds reach +/-(255 + 255 + 15); one extra bit keeps compares exact.
  localparam int BOUND_BITS = ((COORD_BITS > 11) ? COORD_BITS : 11) + 1;
  localparam int NUM_PARTS  = 5;

  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [2:0] {
    REG_ARM_LENGTH    = 3'd0,
    REG_CENTRE_GAP    = 3'd1,
    REG_ARM_WIDTH     = 3'd2,
    REG_OUTLINE_WIDTH = 3'd3,
    REG_FILL_COLOR    = 3'd4,
    REG_EDGE_COLOR    = 3'd5,
    REG_DOT_ENABLE    = 3'd6,
    REG_NONE          = 3'd7
  } reg_idx_e;

  localparam logic [7:0]            ARM_LENGTH_RST    = 8'd4;
  localparam logic [7:0]            CENTRE_GAP_RST    = 8'd2;
  localparam logic [7:0]            ARM_WIDTH_RST     = 8'd1;
  localparam logic [3:0]            OUTLINE_WIDTH_RST = 4'd0;
  localparam logic [COLOR_BITS-1:0] FILL_COLOR_RST    = 32'hFF00FF00;
  localparam logic [COLOR_BITS-1:0] EDGE_COLOR_RST    = 32'hFF000000;
  localparam logic                  DOT_ENABLE_RST    = 1'b0;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
  } pixel_req_t;

  typedef struct packed {
    logic                  covered;
    logic [COLOR_BITS-1:0] pixel_color;
  } pixel_rsp_t;

  typedef struct packed {
    logic signed [BOUND_BITS-1:0] x0;
    logic signed [BOUND_BITS-1:0] y0;
    logic signed [BOUND_BITS-1:0] x1;
    logic signed [BOUND_BITS-1:0] y1;
  } rect_t;

  typedef struct packed {
    logic fill_hit;
    logic edge_hit;
  } part_hit_t;

endpackage

/* hw/rtl/rop_part.sv */
// Hit test of one reticle part: filled rectangle plus four pinwheel
// outline strips. Purely combinational. Uses rop_pkg.
module rop_part (
  input  logic signed [rop_pkg::BOUND_BITS-1:0] px_i,
  input  logic signed [rop_pkg::BOUND_BITS-1:0] py_i,
  input  rop_pkg::rect_t                        rect_i,
  input  logic [3:0]                            outline_i,
  output rop_pkg::part_hit_t                    hit_o
);

  logic signed [rop_pkg::BOUND_BITS-1:0] o_s;
  logic signed [rop_pkg::BOUND_BITS-1:0] x0m_o, y0m_o, x1p_o, y1p_o;
  logic signed [rop_pkg::BOUND_BITS-1:0] x0m_1, y0m_1, x1p_1, y1p_1;
  logic strip_top, strip_right, strip_bot, strip_left;

  assign o_s   = signed'(rop_pkg::BOUND_BITS'(outline_i));
  assign x0m_o = rect_i.x0 - o_s;
  assign y0m_o = rect_i.y0 - o_s;
  assign x1p_o = rect_i.x1 + o_s;
  assign y1p_o = rect_i.y1 + o_s;
  assign x0m_1 = rect_i.x0 - rop_pkg::BOUND_BITS'(1);
  assign y0m_1 = rect_i.y0 - rop_pkg::BOUND_BITS'(1);
  assign x1p_1 = rect_i.x1 + rop_pkg::BOUND_BITS'(1);
  assign y1p_1 = rect_i.y1 + rop_pkg::BOUND_BITS'(1);

  assign strip_top   = (px_i >= x0m_o) && (px_i <= rect_i.x1) &&
                       (py_i >= y0m_o) && (py_i <= y0m_1);
  assign strip_right = (px_i >= x1p_1) && (px_i <= x1p_o) &&
                       (py_i >= y0m_o) && (py_i <= rect_i.y1);
  assign strip_bot   = (px_i >= rect_i.x0) && (px_i <= x1p_o) &&
                       (py_i >= y1p_1) && (py_i <= y1p_o);
  assign strip_left  = (px_i >= x0m_o) && (px_i <= x0m_1) &&
                       (py_i >= rect_i.y0) && (py_i <= y1p_o);

  assign hit_o.fill_hit = (px_i >= rect_i.x0) && (px_i <= rect_i.x1) &&
                          (py_i >= rect_i.y0) && (py_i <= rect_i.y1);
  assign hit_o.edge_hit = (outline_i != 4'd0) &&
                          (strip_top || strip_right || strip_bot || strip_left);

endmodule

/* hw/rtl/reticle_overlay_pixel.sv */
// Reticle overlay per-pixel coverage and color, with APB-style register
// port. Uses rop_pkg and rop_part.
//
// Usage:
//   Request channel in_valid_i / in_stall_o / in_data_i carries a pixel
//   offset from the reticle center (x right, y down, two's complement).
//   Result channel out_valid_o / out_stall_i / out_data_o returns covered
//   and pixel_color (zero when not covered), one result per request, in
//   order.
//   A request accepted is registered in the input register; its result
//   is registered in the result register and visible from then on.
//   Throughput: one request per clock unless out_stall_i holds the
//   results back. Every part test is a set of compares between the input
//   register and the result register, so nothing iterates.
//   Stall: while out_stall_i holds a full result register, the input
//   register still takes one request; once it is full too, in_stall_o
//   rises and the block holds everything until the result is taken.
//   Reset: rst_ni clears both valid flags and loads the register defaults
//   (arm length 4, gap 2, width 1, no outline, no center dot).
//   Registers are written at byte address 4*index; write them only while
//   no request is in flight.
module reticle_overlay_pixel (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  rop_pkg::pixel_req_t                in_data_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output rop_pkg::pixel_rsp_t                out_data_o,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rop_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [rop_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [rop_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                               pready
);

  localparam int BW = rop_pkg::BOUND_BITS;

  // ---------------- registers ----------------
  logic [7:0]                     arm_length_q, centre_gap_q, arm_width_q;
  logic [3:0]                     outline_width_q;
  logic [rop_pkg::COLOR_BITS-1:0] fill_color_q, edge_color_q;
  logic                           dot_enable_q;
  rop_pkg::reg_idx_e              reg_idx;
  logic                           cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = rop_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_length_q    <= rop_pkg::ARM_LENGTH_RST;
      centre_gap_q    <= rop_pkg::CENTRE_GAP_RST;
      arm_width_q     <= rop_pkg::ARM_WIDTH_RST;
      outline_width_q <= rop_pkg::OUTLINE_WIDTH_RST;
      fill_color_q    <= rop_pkg::FILL_COLOR_RST;
      edge_color_q    <= rop_pkg::EDGE_COLOR_RST;
      dot_enable_q    <= rop_pkg::DOT_ENABLE_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        rop_pkg::REG_ARM_LENGTH:    arm_length_q    <= pwdata[7:0];
        rop_pkg::REG_CENTRE_GAP:    centre_gap_q    <= pwdata[7:0];
        rop_pkg::REG_ARM_WIDTH:     arm_width_q     <= pwdata[7:0];
        rop_pkg::REG_OUTLINE_WIDTH: outline_width_q <= pwdata[3:0];
        rop_pkg::REG_FILL_COLOR:    fill_color_q    <= pwdata;
        rop_pkg::REG_EDGE_COLOR:    edge_color_q    <= pwdata;
        rop_pkg::REG_DOT_ENABLE:    dot_enable_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      rop_pkg::REG_ARM_LENGTH:    prdata = rop_pkg::CFG_DATA_BITS'(arm_length_q);
      rop_pkg::REG_CENTRE_GAP:    prdata = rop_pkg::CFG_DATA_BITS'(centre_gap_q);
      rop_pkg::REG_ARM_WIDTH:     prdata = rop_pkg::CFG_DATA_BITS'(arm_width_q);
      rop_pkg::REG_OUTLINE_WIDTH: prdata = rop_pkg::CFG_DATA_BITS'(outline_width_q);
      rop_pkg::REG_FILL_COLOR:    prdata = fill_color_q;
      rop_pkg::REG_EDGE_COLOR:    prdata = edge_color_q;
      rop_pkg::REG_DOT_ENABLE:    prdata = rop_pkg::CFG_DATA_BITS'(dot_enable_q);
      default:                    prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic                in_valid_q, out_valid_q;
  rop_pkg::pixel_req_t in_data_q;
  rop_pkg::pixel_rsp_t out_data_q, out_data_d;
  logic                out_ready, in_ready;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_ready   = !in_valid_q || out_ready;
  assign in_stall_o = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready)  in_valid_q  <= in_valid_i;
      if (out_ready) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) in_data_q  <= in_data_i;
    if (out_ready && in_valid_q) out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------- part bounds ----------------
  logic signed [BW-1:0] px_s, py_s;
  logic signed [BW-1:0] t_s, h_s, g_s, s_s, lo_s, hi_s;
  logic signed [BW-1:0] near_s, far_s;
  rop_pkg::rect_t       rects [rop_pkg::NUM_PARTS];
  rop_pkg::part_hit_t   hits  [rop_pkg::NUM_PARTS];

  assign px_s   = BW'(in_data_q.pixel_x);
  assign py_s   = BW'(in_data_q.pixel_y);
  assign t_s    = signed'(BW'(arm_width_q));
  assign h_s    = signed'(BW'(arm_width_q[7:1]));
  assign g_s    = signed'(BW'(centre_gap_q));
  assign s_s    = signed'(BW'(arm_length_q));
  assign lo_s   = -h_s;
  assign hi_s   = t_s - h_s;
  assign near_s = g_s + BW'(1);
  assign far_s  = g_s + s_s;

  // part order: dot, left, right, top, bottom
  assign rects[0] = '{x0: lo_s,    y0: lo_s,    x1: hi_s,    y1: hi_s};
  assign rects[1] = '{x0: -far_s,  y0: lo_s,    x1: -near_s, y1: hi_s};
  assign rects[2] = '{x0: near_s,  y0: lo_s,    x1: far_s,   y1: hi_s};
  assign rects[3] = '{x0: lo_s,    y0: -far_s,  x1: hi_s,    y1: -near_s};
  assign rects[4] = '{x0: lo_s,    y0: near_s,  x1: hi_s,    y1: far_s};

  for (genvar p = 0; p < rop_pkg::NUM_PARTS; p++) begin : g_part
    rop_part u_part (
      .px_i     (px_s),
      .py_i     (py_s),
      .rect_i   (rects[p]),
      .outline_i(outline_width_q),
      .hit_o    (hits[p])
    );
  end

  // Later parts paint over earlier ones; the dot only when enabled.
  always_comb begin
    out_data_d = '0;
    for (int p = 0; p < rop_pkg::NUM_PARTS; p++) begin
      if (p != 0 || dot_enable_q) begin
        if (hits[p].fill_hit) begin
          out_data_d.covered     = 1'b1;
          out_data_d.pixel_color = fill_color_q;
        end
        if (hits[p].edge_hit) begin
          out_data_d.covered     = 1'b1;
          out_data_d.pixel_color = edge_color_q;
        end
      end
    end
  end

endmodule

/* tb/tb_top.sv */
// Self-checking bench for reticle_overlay_pixel: drives pixel requests with random
// gaps and stalls, programs the registers over APB between phases, and checks every
// result against a behavioral coverage/color predictor. Depends on rop_pkg.
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES     = 10;
  localparam int PHASE_ITEMS    = 133;

  localparam int CFG_ZERO   = 0;
  localparam int CFG_MAX    = 1;
  localparam int CFG_RANDOM = 2;

  // Holds a copy of the registers and the queue of predicted results.
  class overlay_scoreboard;
    logic [7:0]                     arm_len;
    logic [7:0]                     gap_len;
    logic [7:0]                     thick;
    logic [3:0]                     edge_w;
    logic [rop_pkg::COLOR_BITS-1:0] fill_col;
    logic [rop_pkg::COLOR_BITS-1:0] edge_col;
    logic                           dot_on;
    rop_pkg::pixel_rsp_t            expected_q[$];
    int                             errors;

    function new();
      arm_len  = rop_pkg::ARM_LENGTH_RST;
      gap_len  = rop_pkg::CENTRE_GAP_RST;
      thick    = rop_pkg::ARM_WIDTH_RST;
      edge_w   = rop_pkg::OUTLINE_WIDTH_RST;
      fill_col = rop_pkg::FILL_COLOR_RST;
      edge_col = rop_pkg::EDGE_COLOR_RST;
      dot_on   = rop_pkg::DOT_ENABLE_RST;
      errors   = 0;
    endfunction

    function void set_reg(rop_pkg::reg_idx_e idx, logic [31:0] val);
      case (idx)
        rop_pkg::REG_ARM_LENGTH:    arm_len  = val[7:0];
        rop_pkg::REG_CENTRE_GAP:    gap_len  = val[7:0];
        rop_pkg::REG_ARM_WIDTH:     thick    = val[7:0];
        rop_pkg::REG_OUTLINE_WIDTH: edge_w   = val[3:0];
        rop_pkg::REG_FILL_COLOR:    fill_col = val;
        rop_pkg::REG_EDGE_COLOR:    edge_col = val;
        rop_pkg::REG_DOT_ENABLE:    dot_on   = val[0];
        default: ;
      endcase
    endfunction

    function bit in_rect(int px, int py, int x0, int y0, int x1, int y1);
      return px >= x0 && px <= x1 && py >= y0 && py <= y1;
    endfunction

    // Fill first, then the four pinwheel strips; a later cover overrides.
    function void lay_part(int px, int py, int x0, int y0, int x1, int y1,
                           inout bit hit, inout logic [rop_pkg::COLOR_BITS-1:0] col);
      int o;
      o = int'(edge_w);
      if (in_rect(px, py, x0, y0, x1, y1)) begin
        hit = 1'b1;
        col = fill_col;
      end
      if (o != 0 && (in_rect(px, py, x0 - o, y0 - o, x1, y0 - 1) ||
                     in_rect(px, py, x1 + 1, y0 - o, x1 + o, y1) ||
                     in_rect(px, py, x0, y1 + 1, x1 + o, y1 + o) ||
                     in_rect(px, py, x0 - o, y0, x0 - 1, y1 + o))) begin
        hit = 1'b1;
        col = edge_col;
      end
    endfunction

    function rop_pkg::pixel_rsp_t predict(rop_pkg::pixel_req_t req);
      rop_pkg::pixel_rsp_t            rsp;
      int                             px, py, t, h, lo, hi, g, s;
      bit                             hit;
      logic [rop_pkg::COLOR_BITS-1:0] col;
      px  = $signed(req.pixel_x);
      py  = $signed(req.pixel_y);
      t   = int'(thick);
      h   = t / 2;
      lo  = -h;
      hi  = t - h;
      g   = int'(gap_len);
      s   = int'(arm_len);
      hit = 1'b0;
      col = '0;
      if (dot_on) lay_part(px, py, lo, lo, hi, hi, hit, col);
      lay_part(px, py, -g - s, lo, -g - 1, hi, hit, col);
      lay_part(px, py, g + 1, lo, g + s, hi, hit, col);
      lay_part(px, py, lo, -g - s, hi, -g - 1, hit, col);
      lay_part(px, py, lo, g + 1, hi, g + s, hit, col);
      rsp.covered     = hit;
      rsp.pixel_color = hit ? col : '0;
      return rsp;
    endfunction

    function void note_request(rop_pkg::pixel_req_t req);
      expected_q.push_back(predict(req));
    endfunction

    function void check_result(rop_pkg::pixel_rsp_t got);
      rop_pkg::pixel_rsp_t want;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: covered=%0d pixel_color=%0h",
               got.covered, got.pixel_color);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.covered !== want.covered) begin
        $error("covered mismatch: expected %0h, got %0h", want.covered, got.covered);
        errors++;
      end
      if (got.pixel_color !== want.pixel_color) begin
        $error("pixel_color mismatch: expected %0h, got %0h",
               want.pixel_color, got.pixel_color);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                              clk_i       = 1'b0;
  logic                              rst_ni      = 1'b0;
  logic                              in_valid_i  = 1'b0;
  logic                              in_stall_o;
  rop_pkg::pixel_req_t               in_data_i   = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  rop_pkg::pixel_rsp_t               out_data_o;
  logic                              psel        = 1'b0;
  logic                              penable     = 1'b0;
  logic                              pwrite      = 1'b0;
  logic [rop_pkg::CFG_ADDR_BITS-1:0] paddr       = '0;
  logic [rop_pkg::CFG_DATA_BITS-1:0] pwdata      = '0;
  logic [rop_pkg::CFG_DATA_BITS-1:0] prdata;
  logic                              pready;

  // Handshake state sampled mid-cycle, used at the following rising edge.
  logic                in_fire  = 1'b0;
  logic                out_fire = 1'b0;
  rop_pkg::pixel_req_t in_req_s;
  rop_pkg::pixel_rsp_t out_rsp_s;

  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  overlay_scoreboard sb = new();

  reticle_overlay_pixel DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    in_fire   = (in_valid_i === 1'b1) && (in_stall_o === 1'b0);
    out_fire  = (out_valid_o === 1'b1) && (out_stall_i === 1'b0);
    in_req_s  = in_data_i;
    out_rsp_s = out_data_o;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) sb.note_request(in_req_s);
      if (out_fire) sb.check_result(out_rsp_s);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_top: errors");
    $finish;
  end

  // Result side: random stall before each result, none during burst stretches.
  initial begin
    int n;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      n = rx_burst ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_fire);
    end
  end

  function automatic rop_pkg::pixel_req_t make_pixel(int x, int y);
    rop_pkg::pixel_req_t r;
    r.pixel_x = rop_pkg::COORD_BITS'(x);
    r.pixel_y = rop_pkg::COORD_BITS'(y);
    return r;
  endfunction

  function automatic rop_pkg::pixel_req_t draw_pixel();
    int reach, band_lo, band_hi, a, b, mode;
    reach   = int'(sb.gap_len) + int'(sb.arm_len) + int'(sb.edge_w) + 3;
    band_lo = -(int'(sb.thick) / 2) - int'(sb.edge_w) - 2;
    band_hi = int'(sb.thick) - int'(sb.thick) / 2 + int'(sb.edge_w) + 2;
    mode    = $urandom_range(0, 9);
    a       = int'($urandom_range(0, 2 * reach)) - reach;
    b       = int'($urandom_range(0, 2 * reach)) - reach;
    if (mode < 2) return make_pixel(int'($urandom), int'($urandom));
    if (mode < 5) return make_pixel(a, b);
    // near one axis, so the arms and their strips get hit often
    b = band_lo + int'($urandom_range(0, band_hi - band_lo));
    if (mode < 8) return make_pixel(a, b);
    return make_pixel(b, a);
  endfunction

  task automatic send_pixel(input rop_pkg::pixel_req_t req);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_fire);
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input rop_pkg::reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic configure(input int kind);
    logic [31:0] junk;
    junk = $urandom;
    case (kind)
      CFG_ZERO: begin
        write_reg(rop_pkg::REG_ARM_LENGTH, 32'd0);
        write_reg(rop_pkg::REG_CENTRE_GAP, 32'd0);
        write_reg(rop_pkg::REG_ARM_WIDTH, 32'd0);
        write_reg(rop_pkg::REG_OUTLINE_WIDTH, 32'd0);
        write_reg(rop_pkg::REG_FILL_COLOR, 32'd0);
        write_reg(rop_pkg::REG_EDGE_COLOR, 32'hFFFF_FFFF);
        write_reg(rop_pkg::REG_DOT_ENABLE, 32'd1);
      end
      CFG_MAX: begin
        write_reg(rop_pkg::REG_ARM_LENGTH, 32'd255);
        write_reg(rop_pkg::REG_CENTRE_GAP, 32'd255);
        write_reg(rop_pkg::REG_ARM_WIDTH, 32'd255);
        write_reg(rop_pkg::REG_OUTLINE_WIDTH, 32'd15);
        write_reg(rop_pkg::REG_FILL_COLOR, 32'hFFFF_FFFF);
        write_reg(rop_pkg::REG_EDGE_COLOR, 32'd0);
        write_reg(rop_pkg::REG_DOT_ENABLE, 32'd1);
      end
      default: begin
        // upper bits carry junk that the register must drop
        write_reg(rop_pkg::REG_ARM_LENGTH, {junk[31:8], 8'($urandom_range(0, 12))});
        write_reg(rop_pkg::REG_CENTRE_GAP, {junk[23:0], 8'($urandom_range(0, 6))});
        write_reg(rop_pkg::REG_ARM_WIDTH, {junk[31:8], 8'($urandom_range(0, 7))});
        write_reg(rop_pkg::REG_OUTLINE_WIDTH, {junk[27:0], 4'($urandom_range(0, 4))});
        write_reg(rop_pkg::REG_FILL_COLOR, $urandom);
        write_reg(rop_pkg::REG_EDGE_COLOR, $urandom);
        write_reg(rop_pkg::REG_DOT_ENABLE, {junk[31:1], 1'($urandom_range(0, 1))});
      end
    endcase
    // out-of-range index: must not disturb anything
    write_reg(rop_pkg::REG_NONE, $urandom);
  endtask

  initial begin
    int dir_x[8];
    int dir_y[8];
    int ph;
    int i;
    int kind;
    dir_x = '{-2048, 2047, 0, -3, 1, 6, -1, 2047};
    dir_y = '{-2048, 2047, 0, 0, -6, 1, 4, -2048};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: defaults, then dot with outline, then empty arms with outline
    for (i = 0; i < 8; i++) send_pixel(make_pixel(dir_x[i], dir_y[i]));
    drain_pipeline();
    write_reg(rop_pkg::REG_DOT_ENABLE, 32'd1);
    write_reg(rop_pkg::REG_OUTLINE_WIDTH, 32'd2);
    for (i = 0; i < 8; i++) send_pixel(make_pixel(dir_x[i], dir_y[i]));
    drain_pipeline();
    write_reg(rop_pkg::REG_DOT_ENABLE, 32'd0);
    write_reg(rop_pkg::REG_ARM_LENGTH, 32'd0);
    write_reg(rop_pkg::REG_CENTRE_GAP, 32'd0);
    write_reg(rop_pkg::REG_ARM_WIDTH, 32'd0);
    write_reg(rop_pkg::REG_OUTLINE_WIDTH, 32'd1);
    for (i = 0; i < 8; i++) send_pixel(make_pixel(dir_x[i], dir_y[i]));

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_pipeline();
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      kind = (ph == 1) ? CFG_ZERO : (ph == 5) ? CFG_MAX : CFG_RANDOM;
      configure(kind);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 3 && i == PHASE_ITEMS / 2) drain_pipeline();
        send_pixel(draw_pixel());
      end
    end

    drain_pipeline();
    if (sb.errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
